[src/chroma_temporal_noise_reducer_core_macros.svh]
// ---------------------------------------------------------------------------
// chroma temporal noise reducer assertion macros
// shared property wrappers clocked on clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef CHROMA_TEMPORAL_NOISE_REDUCER_CORE_MACROS_SVH
`define CHROMA_TEMPORAL_NOISE_REDUCER_CORE_MACROS_SVH

// same-cycle implication
`define CTNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ctnr_pkg.sv]
// ---------------------------------------------------------------------------
// ctnr_pkg
// shared types, codes and sizes of the chroma temporal noise reducer
// ---------------------------------------------------------------------------
`default_nettype none

package ctnr_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SUM_BITS    = 32;
  localparam int LIMIT_W     = 32;
  localparam int CMP_W       = (SUM_BITS > LIMIT_W) ? SUM_BITS : LIMIT_W;
  localparam int ADD_W       = 11;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_PROC  = 2'd1;
  localparam logic [1:0] ACT_LOAD  = 2'd2;

  localparam logic [1:0] PLANE_LUMA = 2'd0;
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] PLANE_V    = 2'd2;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_PROC  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  localparam logic REG_DIFF_LIMIT    = 1'b0;
  localparam logic REG_CHROMA_IN_CUT = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        plane;
    logic [ADDR_W-1:0] addr_l;
    logic [ADDR_W-1:0] addr_c;
    logic [7:0]        data;
    logic [7:0]        ccur;
    logic [7:0]        cprev;
    logic [ADD_W-1:0]  add;
    logic              check;
  } q_entry_t;

  typedef struct packed {
    logic clearing;
    logic cut_seen;
    logic frame_pop;
  } back_status_t;

endpackage

`default_nettype wire

[src/ctnr_front.sv]
// ---------------------------------------------------------------------------
// ctnr_front
// classifies accepted items, computes luma average, table addresses and
// the difference amount for the frame sum
// ---------------------------------------------------------------------------
`default_nettype none

module ctnr_front (
  input  wire logic              accept,
  input  wire logic [1:0]        action,
  input  wire logic [1:0]        plane,
  input  wire logic [7:0]        luma_tl,
  input  wire logic [7:0]        luma_tr,
  input  wire logic [7:0]        luma_bl,
  input  wire logic [7:0]        luma_br,
  input  wire logic [7:0]        luma_prev,
  input  wire logic [7:0]        chroma_cur,
  input  wire logic [7:0]        chroma_prev,
  input  wire logic              row_end,
  input  wire logic [8:0]        table_index,
  input  wire logic [7:0]        table_value,
  input  wire logic              chroma_in_cut,
  output logic                   push,
  output ctnr_pkg::q_entry_t     entry
);
  import ctnr_pkg::*;

  logic [9:0]        lsum;
  logic [7:0]        ldown;
  logic [7:0]        labs;
  logic [7:0]        cabs;
  logic [ADD_W-1:0]  cadd;
  logic              keep;

  always_comb begin
    lsum  = 10'(luma_tl) + 10'(luma_tr) + 10'(luma_bl) + 10'(luma_br) + 10'd2;
    ldown = lsum[9:2];
    labs  = (ldown >= luma_prev) ? ldown - luma_prev : luma_prev - ldown;
    cabs  = (chroma_cur >= chroma_prev) ? chroma_cur - chroma_prev
                                        : chroma_prev - chroma_cur;
    cadd  = chroma_in_cut ? ADD_W'(cabs) : '0;

    entry        = '0;
    entry.plane  = plane;
    entry.ccur   = chroma_cur;
    entry.cprev  = chroma_prev;
    keep         = 1'b0;
    case (action)
      ACT_FRAME: begin
        entry.kind = KIND_FRAME;
        keep       = 1'b1;
      end
      ACT_LOAD: begin
        entry.kind   = KIND_LOAD;
        entry.addr_l = table_index[ADDR_W-1:0];
        entry.data   = table_value;
        keep         = (plane == PLANE_LUMA) || (plane == PLANE_U) || (plane == PLANE_V);
      end
      ACT_PROC: begin
        entry.kind   = KIND_PROC;
        entry.addr_l = ADDR_W'({1'b0, ldown} + 9'd256 - {1'b0, luma_prev});
        entry.addr_c = ADDR_W'({1'b0, chroma_cur} + 9'd256 - {1'b0, chroma_prev});
        entry.data   = ldown;
        keep         = (plane == PLANE_U) || (plane == PLANE_V);
        if (plane == PLANE_U) begin
          entry.add   = ADD_W'({labs, 2'b00}) + cadd;
          entry.check = row_end;
        end else begin
          entry.add   = cadd;
          entry.check = row_end && chroma_in_cut;
        end
      end
      default: keep = 1'b0;
    endcase
    push = accept && keep;
  end

endmodule

`default_nettype wire

[src/ctnr_queue.sv]
// ---------------------------------------------------------------------------
// ctnr_queue
// short in-order queue between the classifying front and the back end
// ---------------------------------------------------------------------------
`default_nettype none

module ctnr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ctnr_pkg::q_entry_t push_entry,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output ctnr_pkg::q_entry_t head
);
  import ctnr_pkg::*;

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     count_r, count_nxt;

  always_comb begin
    full       = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
    not_empty  = (count_r != '0);
    head       = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[src/ctnr_back.sv]
// ---------------------------------------------------------------------------
// ctnr_back
// weight tables, frame difference sum and the blend pipeline
// ---------------------------------------------------------------------------
`default_nettype none

module ctnr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_not_empty,
  input  wire ctnr_pkg::q_entry_t   head,
  output logic                      pop,
  input  wire logic [31:0]          diff_limit,
  output ctnr_pkg::back_status_t    status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_chroma_out,
  output logic [7:0]                out_luma_down,
  output logic                      out_scene_cut
);
  import ctnr_pkg::*;

  logic [7:0] luma_mem [TABLE_DEPTH];
  logic [7:0] u_mem    [TABLE_DEPTH];
  logic [7:0] v_mem    [TABLE_DEPTH];

  logic [ADDR_W:0]      clr_cnt_r, clr_cnt_nxt;
  logic                 clearing;
  logic                 adv;
  logic                 is_proc, is_load, is_frame;
  logic                 we_l, we_u, we_v;
  logic [ADDR_W-1:0]    waddr;
  logic [7:0]           wdata;

  logic [SUM_BITS-1:0]  diff_sum_r, diff_sum_nxt;
  logic                 cut_r, cut_nxt;
  logic [SUM_BITS:0]    sum_ext;
  logic [SUM_BITS-1:0]  sum_sat;

  logic                 s1_v_r;
  logic [1:0]           s1_plane_r;
  logic [7:0]           s1_ccur_r, s1_cprev_r, s1_ldown_r;
  logic                 s1_cut_r;
  logic [7:0]           lrd_r, urd_r, vrd_r;

  logic                 s2_v_r;
  logic [15:0]          s2_w_r;
  logic [7:0]           s2_ccur_r, s2_cprev_r, s2_ldown_r;
  logic                 s2_cut_r;

  logic signed [8:0]    dlt;
  logic signed [25:0]   prod;
  logic signed [25:0]   total;

  logic                 out_valid_r;
  logic [7:0]           chroma_r, ldown_r;
  logic                 cut_out_r;

  always_comb begin
    clearing    = !clr_cnt_r[ADDR_W];
    clr_cnt_nxt = clearing ? clr_cnt_r + 1'b1 : clr_cnt_r;
    adv         = !out_valid_r || out_ready;
    pop         = adv && q_not_empty && !clearing;
    is_proc     = pop && (head.kind == KIND_PROC);
    is_load     = pop && (head.kind == KIND_LOAD);
    is_frame    = pop && (head.kind == KIND_FRAME);

    waddr = clearing ? clr_cnt_r[ADDR_W-1:0] : head.addr_l;
    wdata = clearing ? 8'd0 : head.data;
    we_l  = clearing || (is_load && (head.plane == PLANE_LUMA));
    we_u  = clearing || (is_load && (head.plane == PLANE_U));
    we_v  = clearing || (is_load && (head.plane == PLANE_V));

    // saturating sum, checked against the limit at row end
    sum_ext = {1'b0, diff_sum_r} + (SUM_BITS+1)'(head.add);
    sum_sat = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
    diff_sum_nxt = diff_sum_r;
    cut_nxt      = cut_r;
    if (is_frame) begin
      diff_sum_nxt = '0;
      cut_nxt      = 1'b0;
    end else if (is_proc && !cut_r) begin
      diff_sum_nxt = sum_sat;
      if (head.check && (CMP_W'(sum_sat) > CMP_W'(diff_limit))) begin
        cut_nxt = 1'b1;
      end
    end

    dlt   = $signed({1'b0, s2_cprev_r}) - $signed({1'b0, s2_ccur_r});
    prod  = $signed({1'b0, s2_w_r}) * dlt;
    total = $signed({2'b00, s2_ccur_r, 16'h8000}) + prod;

    status.clearing  = clearing;
    status.cut_seen  = cut_r;
    status.frame_pop = is_frame;

    out_valid      = out_valid_r;
    out_chroma_out = chroma_r;
    out_luma_down  = ldown_r;
    out_scene_cut  = cut_out_r;
  end

  always_ff @(posedge clk) begin
    if (we_l) begin
      luma_mem[waddr] <= wdata;
    end
    if (adv) begin
      lrd_r <= luma_mem[head.addr_l];
    end
  end

  always_ff @(posedge clk) begin
    if (we_u) begin
      u_mem[waddr] <= wdata;
    end
    if (adv) begin
      urd_r <= u_mem[head.addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (we_v) begin
      v_mem[waddr] <= wdata;
    end
    if (adv) begin
      vrd_r <= v_mem[head.addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      diff_sum_r  <= '0;
      cut_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      diff_sum_r <= diff_sum_nxt;
      cut_r      <= cut_nxt;
      if (adv) begin
        s1_v_r      <= is_proc;
        s2_v_r      <= s1_v_r;
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_plane_r <= head.plane;
      s1_ccur_r  <= head.ccur;
      s1_cprev_r <= head.cprev;
      s1_ldown_r <= head.data;
      s1_cut_r   <= cut_nxt;

      s2_w_r     <= 16'(lrd_r) * 16'((s1_plane_r == PLANE_U) ? urd_r : vrd_r);
      s2_ccur_r  <= s1_ccur_r;
      s2_cprev_r <= s1_cprev_r;
      s2_ldown_r <= s1_ldown_r;
      s2_cut_r   <= s1_cut_r;

      chroma_r   <= s2_cut_r ? s2_ccur_r : total[23:16];
      ldown_r    <= s2_ldown_r;
      cut_out_r  <= s2_cut_r;
    end
  end

endmodule

`default_nettype wire

[src/chroma_temporal_noise_reducer_core.sv]
// ---------------------------------------------------------------------------
// chroma_temporal_noise_reducer_core
// Recursive temporal chroma filter for 4:2:0 video, one chroma sample per
// item. After reset the weight tables are cleared, during which in_ready
// stays low; configuration writes are taken at any time. Afterwards the back
// end retires one queued item per cycle while the output register is free,
// so the block sustains one item per clock; a processed sample passes the
// queue and the s1, s2 and output registers before it appears at the
// output. A four-entry queue lets input keep flowing while a result waits on
// out_ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "chroma_temporal_noise_reducer_core_macros.svh"

module chroma_temporal_noise_reducer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [1:0]  in_plane,
  input  wire logic [7:0]  in_luma_tl,
  input  wire logic [7:0]  in_luma_tr,
  input  wire logic [7:0]  in_luma_bl,
  input  wire logic [7:0]  in_luma_br,
  input  wire logic [7:0]  in_luma_prev,
  input  wire logic [7:0]  in_chroma_cur,
  input  wire logic [7:0]  in_chroma_prev,
  input  wire logic        in_row_end,
  input  wire logic [8:0]  in_table_index,
  input  wire logic [7:0]  in_table_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_chroma_out,
  output logic [7:0]       out_luma_down,
  output logic             out_scene_cut
);
  import ctnr_pkg::*;

  logic [31:0]   diff_limit_r;
  logic          chroma_in_cut_r;
  logic          accept;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  q_entry_t      push_entry;
  q_entry_t      head;
  back_status_t  status;

  always_comb begin
    cfg_ready = 1'b1;
    in_ready  = !q_full && !status.clearing;
    accept    = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_limit_r    <= '1;
      chroma_in_cut_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIFF_LIMIT:    diff_limit_r    <= cfg_data;
        REG_CHROMA_IN_CUT: chroma_in_cut_r <= cfg_data[0];
        default:           diff_limit_r    <= diff_limit_r;
      endcase
    end
  end

  ctnr_front u_front (
    .accept        (accept),
    .action        (in_action),
    .plane         (in_plane),
    .luma_tl       (in_luma_tl),
    .luma_tr       (in_luma_tr),
    .luma_bl       (in_luma_bl),
    .luma_br       (in_luma_br),
    .luma_prev     (in_luma_prev),
    .chroma_cur    (in_chroma_cur),
    .chroma_prev   (in_chroma_prev),
    .row_end       (in_row_end),
    .table_index   (in_table_index),
    .table_value   (in_table_value),
    .chroma_in_cut (chroma_in_cut_r),
    .push          (push),
    .entry         (push_entry)
  );

  ctnr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  ctnr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .head           (head),
    .pop            (pop),
    .diff_limit     (diff_limit_r),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chroma_out (out_chroma_out),
    .out_luma_down  (out_luma_down),
    .out_scene_cut  (out_scene_cut)
  );

  `CTNR_ASSERT_NOW(a_no_accept_clearing, status.clearing, !in_ready, "item accepted during table clear")
  `CTNR_ASSERT_NEXT(a_clear_once, !status.clearing, !status.clearing, "table clear restarted")
  `CTNR_ASSERT_NEXT(a_cut_sticky, status.cut_seen && !status.frame_pop, status.cut_seen, "scene cut dropped without frame start")
  `CTNR_ASSERT_NOW(a_pop_not_empty, pop, q_not_empty && !status.clearing, "queue popped while empty or clearing")

endmodule

`default_nettype wire

[bench/tb_chroma_temporal_noise_reducer_core.sv]
// ---------------------------------------------------------------------------
// tb_chroma_temporal_noise_reducer_core
// Self-checking bench for the chroma temporal noise reducer. A directed table
// covers the field extremes, ignored items, table loads and scene cuts. It is
// followed by random frames of U and V rows run under several threshold
// settings. Every accepted item goes through a bit-accurate model of the
// filter. Each output item is compared in order with the model's result, or
// with the table's expected value for typed rows, while both handshakes stall at random except in the last two phases.
// ---------------------------------------------------------------------------
module tb_chroma_temporal_noise_reducer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ctnr_pkg::*;

  localparam logic [1:0] ACT_NONE   = 2'd3;
  localparam logic [1:0] PLANE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY_PAD = 12;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 160;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] plane;
    logic [7:0] tl;
    logic [7:0] tr;
    logic [7:0] bl;
    logic [7:0] br;
    logic [7:0] lprev;
    logic [7:0] ccur;
    logic [7:0] cprev;
    logic       row_end;
    logic [8:0] tidx;
    logic [7:0] tval;
  } stim_t;

  localparam int STIM_W = $bits(stim_t);

  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] luma;
    logic       cut;
  } pix_t;

  typedef struct {
    stim_t s;
    bit    typed;
    pix_t  px;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [1:0]  in_plane;
  logic [7:0]  in_luma_tl;
  logic [7:0]  in_luma_tr;
  logic [7:0]  in_luma_bl;
  logic [7:0]  in_luma_br;
  logic [7:0]  in_luma_prev;
  logic [7:0]  in_chroma_cur;
  logic [7:0]  in_chroma_prev;
  logic        in_row_end;
  logic [8:0]  in_table_index;
  logic [7:0]  in_table_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_chroma_out;
  logic [7:0]  out_luma_down;
  logic        out_scene_cut;

  logic [7:0]          luma_w [TABLE_DEPTH];
  logic [7:0]          u_w    [TABLE_DEPTH];
  logic [7:0]          v_w    [TABLE_DEPTH];
  logic [SUM_BITS-1:0] frame_sum;
  logic                cut_flag;
  logic [31:0]         limit_reg;
  logic                cin_reg;

  pix_t     pending_pixels[$];
  dir_row_t dir_rows[$];
  pix_t     want_px;
  int       mismatches;
  int       cycles;
  int       items_sent;
  int       send_idle;
  int       recv_idle;

  chroma_temporal_noise_reducer_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_plane       (in_plane),
    .in_luma_tl     (in_luma_tl),
    .in_luma_tr     (in_luma_tr),
    .in_luma_bl     (in_luma_bl),
    .in_luma_br     (in_luma_br),
    .in_luma_prev   (in_luma_prev),
    .in_chroma_cur  (in_chroma_cur),
    .in_chroma_prev (in_chroma_prev),
    .in_row_end     (in_row_end),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chroma_out (out_chroma_out),
    .out_luma_down  (out_luma_down),
    .out_scene_cut  (out_scene_cut)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit advance_filter(input stim_t s, output pix_t r);
    logic [9:0]          lsum;
    logic [7:0]          ldown;
    logic [8:0]          lidx;
    logic [8:0]          cidx;
    int unsigned         w;
    int unsigned         blend;
    int unsigned         ldiff;
    int unsigned         cdiff;
    int unsigned         add;
    logic [SUM_BITS:0]   acc;
    bit                  check;
    r = '0;
    case (s.action)
      ACT_FRAME: begin
        frame_sum = '0;
        cut_flag  = 1'b0;
        return 1'b0;
      end
      ACT_LOAD: begin
        case (s.plane)
          PLANE_LUMA: luma_w[s.tidx] = s.tval;
          PLANE_U:    u_w[s.tidx]    = s.tval;
          PLANE_V:    v_w[s.tidx]    = s.tval;
          default: ;
        endcase
        return 1'b0;
      end
      ACT_PROC: ;
      default: return 1'b0;
    endcase
    if (s.plane != PLANE_U && s.plane != PLANE_V) return 1'b0;
    lsum  = 10'(s.tl) + 10'(s.tr) + 10'(s.bl) + 10'(s.br) + 10'd2;
    ldown = lsum[9:2];
    lidx  = 9'(ldown) + 9'd256 - 9'(s.lprev);
    cidx  = 9'(s.ccur) + 9'd256 - 9'(s.cprev);
    w = int'(luma_w[lidx]) * int'((s.plane == PLANE_U) ? u_w[cidx] : v_w[cidx]);
    blend = (w * s.cprev + (32'd65536 - w) * s.ccur + 32'd32768) >> 16;
    ldiff = (ldown >= s.lprev) ? ldown - s.lprev : s.lprev - ldown;
    cdiff = (s.ccur >= s.cprev) ? s.ccur - s.cprev : s.cprev - s.ccur;
    if (!cut_flag) begin
      add = 0;
      if (s.plane == PLANE_U) begin
        add = ldiff << 2;
        if (cin_reg) add += cdiff;
        check = s.row_end;
      end else begin
        if (cin_reg) add = cdiff;
        check = s.row_end && cin_reg;
      end
      acc = {1'b0, frame_sum} + (SUM_BITS+1)'(add);
      frame_sum = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
      if (check && frame_sum > limit_reg) cut_flag = 1'b1;
    end
    r.chroma = cut_flag ? s.ccur : blend[7:0];
    r.luma   = ldown;
    r.cut    = cut_flag;
    return 1'b1;
  endfunction

  function automatic stim_t mk(input logic [1:0] act, input logic [1:0] pl,
                               input int tl, input int tr,
                               input int bl, input int br,
                               input int lp, input int cc,
                               input int cp, input int re,
                               input int ti, input int tv);
    stim_t s;
    s = '{act, pl, 8'(tl), 8'(tr), 8'(bl), 8'(br), 8'(lp), 8'(cc), 8'(cp), 1'(re),
          9'(ti), 8'(tv)};
    return s;
  endfunction

  function automatic logic [7:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic stim_t rand_sample(input logic [1:0] pl, input logic re);
    stim_t s;
    int    lb;
    int    cb;
    s = STIM_W'({$urandom, $urandom, $urandom});
    s.action  = ACT_PROC;
    s.plane   = pl;
    s.row_end = re;
    if ($urandom_range(99) < 70) begin
      lb = $urandom_range(255);
      cb = $urandom_range(255);
      s.tl    = near(lb, 3);
      s.tr    = near(lb, 3);
      s.bl    = near(lb, 3);
      s.br    = near(lb, 3);
      s.lprev = near(lb, 8);
      s.ccur  = cb[7:0];
      s.cprev = near(cb, 12);
    end
    return s;
  endfunction

  function automatic stim_t rand_load(input logic [1:0] pl);
    stim_t s;
    s = STIM_W'({$urandom, $urandom, $urandom});
    s.action = ACT_LOAD;
    s.plane  = pl;
    s.tval   = 8'($urandom);
    if ($urandom_range(99) < 80) s.tidx = 9'(256 + int'($urandom_range(40)) - 20);
    else s.tidx = 9'($urandom);
    return s;
  endfunction

  function automatic void note_error(input string what, input pix_t want, input pix_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected chroma %0d luma %0d cut %0d, got chroma %0d luma %0d cut %0d",
               $time, what, want.chroma, want.luma, want.cut, got.chroma, got.luma, got.cut);
  endfunction

  task automatic send_item(input stim_t s, input bit typed, input pix_t typed_px);
    pix_t px;
    bit   has;
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_action      = s.action;
    in_plane       = s.plane;
    in_luma_tl     = s.tl;
    in_luma_tr     = s.tr;
    in_luma_bl     = s.bl;
    in_luma_br     = s.br;
    in_luma_prev   = s.lprev;
    in_chroma_cur  = s.ccur;
    in_chroma_prev = s.cprev;
    in_row_end     = s.row_end;
    in_table_index = s.tidx;
    in_table_value = s.tval;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = advance_filter(s, px);
    if (has) pending_pixels.push_back(typed ? typed_px : px);
  endtask

  task automatic send_counted(input stim_t s);
    send_item(s, 1'b0, '0);
    items_sent++;
  endtask

  task automatic send_noise();
    stim_t s;
    s = STIM_W'({$urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: s.action = ACT_NONE;
      1: begin s.action = ACT_PROC; s.plane = PLANE_LUMA; end
      2: begin s.action = ACT_PROC; s.plane = PLANE_NONE; end
      default: begin s.action = ACT_LOAD; s.plane = PLANE_NONE; end
    endcase
    send_item(s, 1'b0, '0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DIFF_LIMIT) limit_reg = data;
    else cin_reg = data[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_frame();
    stim_t s;
    int    nrows;
    int    len;
    s = STIM_W'({$urandom, $urandom, $urandom});
    s.action = ACT_FRAME;
    send_counted(s);
    repeat ($urandom_range(4)) send_counted(rand_load(2'($urandom_range(2))));
    nrows = $urandom_range(1, 3);
    for (int r = 0; r < nrows; r++) begin
      for (int p = 0; p < 2; p++) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 5) send_noise();
          send_counted(rand_sample(p == 0 ? PLANE_U : PLANE_V,
                                   (i == len - 1) || ($urandom_range(99) < 5)));
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_error("unexpected item", '0, {out_chroma_out, out_luma_down, out_scene_cut});
      end else begin
        want_px = pending_pixels.pop_front();
        if (want_px.chroma !== out_chroma_out || want_px.luma !== out_luma_down ||
            want_px.cut !== out_scene_cut)
          note_error("mismatch", want_px, {out_chroma_out, out_luma_down, out_scene_cut});
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] lim;
    mismatches = 0;
    cycles     = 0;
    items_sent = 0;
    send_idle  = 27;
    recv_idle  = 62;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_action  = ACT_FRAME;
    in_plane   = PLANE_LUMA;
    in_luma_tl = '0;
    in_luma_tr = '0;
    in_luma_bl = '0;
    in_luma_br = '0;
    in_luma_prev   = '0;
    in_chroma_cur  = '0;
    in_chroma_prev = '0;
    in_row_end     = 1'b0;
    in_table_index = '0;
    in_table_value = '0;
    out_ready  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      luma_w[i] = '0;
      u_w[i]    = '0;
      v_w[i]    = '0;
    end
    frame_sum = '0;
    cut_flag  = 1'b0;
    limit_reg = '1;
    cin_reg   = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(REG_DIFF_LIMIT, 32'd100);
    write_reg(REG_CHROMA_IN_CUT, 32'd1);

    // zero tables: output follows current chroma
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                         1'b1, pix_t'{8'd0, 8'd0, 1'b0}});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_V, 255, 255, 255, 255, 255, 255, 255, 1, 511, 255),
                         1'b1, pix_t'{8'd255, 8'd255, 1'b0}});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 255, 0, 0, 0, 0, 200, 10, 0, 0, 0),
                         1'b1, pix_t'{8'd200, 8'd64, 1'b0}});
    // ignored items
    dir_rows.push_back('{mk(ACT_NONE, PLANE_U, 1, 2, 3, 4, 5, 6, 7, 1, 8, 9), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_LUMA, 9, 9, 9, 9, 0, 5, 6, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_NONE, 9, 9, 9, 9, 0, 5, 6, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 320, 255), 1'b0, '0});
    // table loads
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_LUMA, 0, 0, 0, 0, 0, 0, 0, 0, 511, 255), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_LUMA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_LUMA, 0, 0, 0, 0, 0, 0, 0, 0, 320, 255), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 0, 446, 255), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_V, 0, 0, 0, 0, 0, 0, 0, 0, 511, 255), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_V, 0, 0, 0, 0, 0, 0, 0, 0, 0, 128), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 0, 256, 200), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_LOAD, PLANE_LUMA, 0, 0, 0, 0, 0, 0, 0, 0, 256, 1), 1'b0, '0});
    // blends with loaded weights
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 255, 0, 0, 0, 0, 200, 10, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // cut on the row end sample itself, then pass through
    dir_rows.push_back('{mk(ACT_PROC, PLANE_V, 255, 255, 255, 255, 0, 255, 0, 1, 0, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 3, 3, 3, 3, 200, 77, 200, 1, 0, 0), 1'b0, '0});
    // new frame clears the cut
    dir_rows.push_back('{mk(ACT_FRAME, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_V, 0, 0, 0, 0, 0, 0, 255, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ACT_PROC, PLANE_U, 255, 255, 255, 255, 255, 255, 0, 0, 0, 0),
                         1'b0, '0});

    foreach (dir_rows[i]) send_item(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].px);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      send_idle = (ph < 2) ? 27 : (ph < 4) ? 62 : 0;
      recv_idle = (ph < 2) ? 62 : (ph < 4) ? 27 : 0;
      case (ph)
        0: lim = '1;
        1: lim = '0;
        2: lim = $urandom_range(3000);
        3: lim = $urandom;
        4: lim = $urandom_range(600);
        default: lim = $urandom_range(3000);
      endcase
      write_reg(REG_DIFF_LIMIT, lim);
      write_reg(REG_CHROMA_IN_CUT,
                {31'($urandom), (ph == 5) ? 1'($urandom) : 1'(ph % 2)});
      if (ph == 0) begin
        // weights around zero difference so most samples blend
        for (int p = 0; p < 3; p++)
          for (int d = -12; d <= 12; d++)
            send_counted(mk(ACT_LOAD, 2'(p), $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom, 256 + d, $urandom));
      end
      while (items_sent < (ph + 1) * PHASE_ITEMS + 75) run_frame();
    end

    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
